// File: sv/b64d_pkg.sv
// b64d_pkg: types, constants and the alphabet lookup for the base64 stream decoder.
// No dependencies; imported by b64d_out_if, b64d_decode, base64_stream_decoder_core and the testbench.
package b64d_pkg;

	localparam logic [7:0] PadChar   = 8'h3D;  // '='
	localparam int         MaxRes    = 3;      // results one character can cause
	localparam int         QDepth    = 6;      // result queue entries
	localparam int         QCntW     = $clog2(QDepth + 1);
	localparam int         ResCntW   = $clog2(MaxRes + 1);
	localparam logic [QCntW-1:0] QAcceptMax = QCntW'(QDepth - MaxRes);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       error;
		logic       run_last;
		logic       message_last;
	} result_t;

	// group state carried from one character to the next
	typedef struct packed {
		logic [1:0]  group_position;
		logic [17:0] sextet_store;
		logic        padding_seen;
		logic        error_latched;
	} dec_state_t;

	typedef struct packed {
		logic [ResCntW-1:0]         count;
		result_t [MaxRes-1:0]       res;
	} dec_out_t;

	typedef struct packed {
		logic       bad;
		logic [5:0] value;
	} sextet_t;

	// A-Z, a-z, 0-9, '+', '/' -> 0..63; everything else is flagged bad
	function automatic sextet_t sextet_of(input logic [7:0] ch);
		sextet_t r;
		r.bad   = 1'b0;
		r.value = 6'd0;
		priority if (ch >= 8'h41 && ch <= 8'h5A) begin
			r.value = 6'(ch - 8'h41);
		end else if (ch >= 8'h61 && ch <= 8'h7A) begin
			r.value = 6'(ch - 8'h61 + 8'd26);
		end else if (ch >= 8'h30 && ch <= 8'h39) begin
			r.value = 6'(ch - 8'h30 + 8'd52);
		end else if (ch == 8'h2B) begin
			r.value = 6'd62;
		end else if (ch == 8'h2F) begin
			r.value = 6'd63;
		end else begin
			r.bad = 1'b1;
		end
		return r;
	endfunction

endpackage

// File: sv/b64d_if.sv
// b64d_in_if / b64d_out_if: valid/ready request channels of the base64 decoder.
// b64d_out_if imports b64d_pkg.
interface b64d_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       message_end;

	modport source (output valid, output symbol, output message_end, input ready);
	modport sink   (input valid, input symbol, input message_end, output ready);
endinterface

interface b64d_out_if import b64d_pkg::*;;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       error;
	logic       run_last;
	logic       message_last;

	modport source (output valid, output data_byte, output error, output run_last,
		output message_last, input ready);
	modport sink   (input valid, input data_byte, input error, input run_last,
		input message_last, output ready);
endinterface

// File: sv/b64d_decode.sv
// b64d_decode: combinational step of the decoder, one character against the group state.
// Produces the next state and up to three results; depends on b64d_pkg.
module b64d_decode import b64d_pkg::*; (
	input  logic [7:0] symbol,
	input  logic       message_end,
	input  dec_state_t state,
	output dec_state_t state_nxt,
	output dec_out_t   dout
);

	sextet_t    sx;
	logic       is_pad;
	logic [5:0] v;
	logic       err;
	logic [5:0] a, b, c;
	logic [7:0] byte0, byte1, byte2;
	logic [ResCntW-1:0] cnt;
	logic       emit;

	always_comb begin
		sx     = sextet_of(symbol);
		is_pad = (symbol == PadChar);
		err    = state.error_latched;
		v      = sx.value;

		if (is_pad) begin
			// '=' only at position 2 (first pad) or 3
			if (state.group_position < 2'd2) err = 1'b1;
			else if (state.group_position == 2'd2 && state.padding_seen) err = 1'b1;
			v = 6'd0;
		end else begin
			if (sx.bad) begin
				err = 1'b1;
				v   = 6'd0;
			end
			if (state.padding_seen) err = 1'b1;
		end
		if (state.group_position == 2'd0 && state.padding_seen) err = 1'b1;
		if (message_end && state.group_position != 2'd3) err = 1'b1;

		a = state.sextet_store[17:12];
		b = state.sextet_store[11:6];
		c = state.sextet_store[5:0];
		byte0 = {a, b[5:4]};
		byte1 = {b[3:0], c[5:2]};
		byte2 = {c[1:0], v};

		if (!is_pad)                cnt = ResCntW'(3);
		else if (state.padding_seen) cnt = ResCntW'(1);
		else                        cnt = ResCntW'(2);

		emit = (state.group_position == 2'd3) && !err;

		dout.res[0] = '{byte0, 1'b0, cnt == ResCntW'(1), message_end && cnt == ResCntW'(1)};
		dout.res[1] = '{byte1, 1'b0, cnt == ResCntW'(2), message_end && cnt == ResCntW'(2)};
		dout.res[2] = '{byte2, 1'b0, cnt == ResCntW'(3), message_end && cnt == ResCntW'(3)};
		if (emit) begin
			dout.count = cnt;
		end else if (message_end && err) begin
			dout.count  = ResCntW'(1);
			dout.res[0] = '{8'd0, 1'b1, 1'b1, 1'b1};
		end else begin
			dout.count = '0;
		end

		if (message_end) begin
			state_nxt = '0;
		end else begin
			state_nxt.padding_seen   = state.padding_seen | is_pad;
			state_nxt.error_latched  = err;
			state_nxt.sextet_store   = (state.group_position == 2'd3) ? 18'd0
				: {state.sextet_store[11:0], v};
			state_nxt.group_position = state.group_position + 2'd1;
		end
	end

endmodule

// File: sv/base64_stream_decoder_core.sv
// base64_stream_decoder_core: top level of the base64 stream decoder.
// Depends on b64d_pkg, b64d_if.sv (channel interfaces) and b64d_decode.
//
// Usage:
//   in_ch  carries one base64 character (symbol) per request, with message_end
//          set on the last character of a message.
//   out_ch carries decoded bytes, one per request. A completed group of four
//          gives one to three bytes; run_last marks the last byte of a group,
//          message_last the last result of the message. A malformed message
//          ends in a single result with error set and data_byte zero; bytes
//          sent earlier in that message stand and are to be dropped downstream.
// Timing:
//   A character is decoded in the cycle it is accepted and its results land
//   in a six-entry registered result queue; if the queue was empty, the first
//   result is offered on out_ch in the next cycle. in_ch takes one character
//   every cycle while the queue holds three results or fewer, which the output
//   drains at one per cycle while out_ch is ready, so a steady text stream
//   runs at one character per cycle (three bytes out per four characters).
// Reset (arst_n low): group state and the queue count are cleared at once.
// Stall: when out_ch is held off, the queue fills and in_ch.ready drops
//   until room for a full group's three bytes is back.
module base64_stream_decoder_core import b64d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	b64d_in_if.sink     in_ch,
	b64d_out_if.source  out_ch
);

	dec_state_t state_q, state_nxt;
	dec_out_t   dout;

	result_t    queue_q [QDepth];
	result_t    queue_nxt [QDepth];
	logic [QCntW-1:0] count_q, count_nxt, base;
	logic       push, pop;

	// decode step: next group state and the results of this character
	b64d_decode u_decode (
		.symbol      (in_ch.symbol),
		.message_end (in_ch.message_end),
		.state       (state_q),
		.state_nxt   (state_nxt),
		.dout        (dout)
	);

	// room for a full group's worth of results regardless of the pop
	assign in_ch.ready = (count_q <= QAcceptMax);
	assign push = in_ch.valid && in_ch.ready;

	assign out_ch.valid        = (count_q != '0);
	assign out_ch.data_byte    = queue_q[0].data_byte;
	assign out_ch.error        = queue_q[0].error;
	assign out_ch.run_last     = queue_q[0].run_last;
	assign out_ch.message_last = queue_q[0].message_last;
	assign pop = out_ch.valid && out_ch.ready;

	// queue with head at entry 0: shift on pop, append behind the survivors
	always_comb begin
		base = count_q - QCntW'(pop);
		for (int i = 0; i < QDepth; i++) begin
			if (pop && i < QDepth - 1) queue_nxt[i] = queue_q[i + 1];
			else                       queue_nxt[i] = queue_q[i];
		end
		if (push) begin
			for (int i = 0; i < QDepth; i++) begin
				for (int k = 0; k < MaxRes; k++) begin
					if (ResCntW'(k) < dout.count && QCntW'(i) == base + QCntW'(k))
						queue_nxt[i] = dout.res[k];
				end
			end
		end
		count_nxt = base + (push ? QCntW'(dout.count) : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			count_q <= '0;
		end else begin
			if (push) state_q <= state_nxt;
			count_q <= count_nxt;
		end
	end

	// payload entries need no reset
	always_ff @(posedge clk) begin
		queue_q <= queue_nxt;
	end

	// queue never overfills
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCntW'(QDepth))
		else $error("result queue count beyond depth");

	// input is held off whenever a full group could overflow the queue
	a_ready_room: assert property (@(posedge clk) disable iff (!arst_n)
		count_q > QAcceptMax |-> !in_ch.ready)
		else $error("input accepted without room for three results");

	// an error result is always the zero-data closing result of a message
	a_error_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.error |->
			out_ch.message_last && out_ch.run_last && out_ch.data_byte == 8'd0)
		else $error("malformed error result");

endmodule

// File: tb/sv/base64_stream_decoder_core_tb.sv
// Self-checking testbench for base64_stream_decoder_core: directed and random base64 messages,
// decoded bytes predicted in the bench and checked in order. Depends on b64d_pkg and b64d_if.sv.
`timescale 1ns / 1ps

module base64_stream_decoder_core_tb;
	import b64d_pkg::*;

	localparam int CycleLimit = 200000;

	typedef logic [7:0] char_q_t[$];
	typedef enum int {NoPad, OnePad, TwoPads} pad_style_e;
	typedef enum int {AnyByte, PadAnywhere, Truncate, TrailingChars} damage_e;

	logic clk = 1'b0;
	logic arst_n;

	b64d_in_if  in_ch();
	b64d_out_if out_ch();

	base64_stream_decoder_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// decoder state as the bench sees it
	logic [1:0]  grp_pos;
	logic [17:0] sextets;
	logic        pad_seen;
	logic        err_latched;

	result_t decoded_queue[$];   // results still owed by the block, oldest first

	int send_idle_pct;
	int recv_idle_pct;
	int symbols_sent;
	int messages_sent;
	int bad_messages;
	int results_checked = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	function automatic void clear_group_state();
		grp_pos     = 2'd0;
		sextets     = 18'd0;
		pad_seen    = 1'b0;
		err_latched = 1'b0;
	endfunction

	// Works out what one accepted character releases and advances the group state.
	function automatic void decode_char(input logic [7:0] sym, input logic last);
		logic [5:0] val;
		logic       bad;
		logic       pad;
		logic       fail;
		logic [7:0] group_bytes [3];
		int         count;
		result_t    r;
		pad = (sym == PadChar);
		bad = 1'b0;
		val = 6'd0;
		if (sym >= 8'h41 && sym <= 8'h5A) begin          // A-Z
			val = 6'(sym - 8'h41);
		end else if (sym >= 8'h61 && sym <= 8'h7A) begin // a-z
			val = 6'(sym - 8'h61 + 8'd26);
		end else if (sym >= 8'h30 && sym <= 8'h39) begin // 0-9
			val = 6'(sym - 8'h30 + 8'd52);
		end else if (sym == 8'h2B) begin                 // '+'
			val = 6'd62;
		end else if (sym == 8'h2F) begin                 // '/'
			val = 6'd63;
		end else begin
			bad = 1'b1;
		end

		fail = err_latched;
		if (pad) begin
			// '=' only at the third or fourth slot, and at the third only as "=="
			if (grp_pos < 2'd2)
				fail = 1'b1;
			else if (grp_pos == 2'd2 && pad_seen)
				fail = 1'b1;
			val = 6'd0;
		end else begin
			if (bad || pad_seen)
				fail = 1'b1;
		end
		if (grp_pos == 2'd0 && pad_seen)
			fail = 1'b1;              // anything after a padded group
		if (last && grp_pos != 2'd3)
			fail = 1'b1;              // length not a multiple of four

		if (grp_pos == 2'd3 && !fail) begin
			group_bytes[0] = {sextets[17:12], sextets[11:10]};
			group_bytes[1] = {sextets[9:6], sextets[5:2]};
			group_bytes[2] = {sextets[1:0], val};
			count = !pad ? 3 : (pad_seen ? 1 : 2);
			for (int k = 0; k < count; k++) begin
				r.data_byte    = group_bytes[k];
				r.error        = 1'b0;
				r.run_last     = (k == count - 1);
				r.message_last = (k == count - 1) && last;
				decoded_queue.push_back(r);
			end
		end else if (last && fail) begin
			r.data_byte    = 8'd0;
			r.error        = 1'b1;
			r.run_last     = 1'b1;
			r.message_last = 1'b1;
			decoded_queue.push_back(r);
			bad_messages++;
		end

		if (last) begin
			clear_group_state();
		end else begin
			if (pad)
				pad_seen = 1'b1;
			err_latched = fail;
			sextets     = (grp_pos == 2'd3) ? 18'd0 : {sextets[11:0], val};
			grp_pos     = grp_pos + 2'd1;
		end
	endfunction

	function automatic logic [7:0] random_alphabet_char();
		int r;
		r = $urandom_range(63);
		if (r < 26)
			return 8'(8'h41 + r);
		else if (r < 52)
			return 8'(8'h61 + r - 26);
		else if (r < 62)
			return 8'(8'h30 + r - 52);
		else if (r == 62)
			return 8'h2B;
		return 8'h2F;
	endfunction

	// Mostly well-formed text with random content; about a third is damaged
	// in one of several ways so that every error path is reached.
	function automatic char_q_t random_message();
		char_q_t msg;
		int      idx;
		repeat ($urandom_range(1, 3) * 4)
			msg.push_back(random_alphabet_char());
		case (pad_style_e'($urandom_range(2)))
			OnePad: begin
				msg[$] = PadChar;
			end
			TwoPads: begin
				msg[$]   = PadChar;
				msg[$-1] = PadChar;
			end
			default: ;
		endcase
		if ($urandom_range(99) < 30) begin
			idx = $urandom_range(msg.size() - 1);
			case (damage_e'($urandom_range(3)))
				AnyByte: begin
					msg[idx] = 8'($urandom_range(255));
				end
				PadAnywhere: begin
					msg[idx] = PadChar;
				end
				Truncate: begin
					repeat ($urandom_range(1, 3))
						void'(msg.pop_back());
				end
				TrailingChars: begin
					repeat ($urandom_range(1, 5))
						msg.push_back($urandom_range(1) ? PadChar : random_alphabet_char());
				end
				default: ;
			endcase
		end
		return msg;
	endfunction

	// One request on in_ch; called at a rising edge, returns at the accepting edge.
	task automatic send_symbol(input logic [7:0] sym, input logic last);
		if ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_ch.valid       <= 1'b1;
		in_ch.symbol      <= sym;
		in_ch.message_end <= last;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
		decode_char(sym, last);
		symbols_sent++;
	endtask

	task automatic send_message(input char_q_t msg);
		foreach (msg[i])
			send_symbol(msg[i], i == msg.size() - 1);
		messages_sent++;
	endtask

	task automatic send_text(input string text);
		char_q_t msg;
		for (int i = 0; i < text.len(); i++)
			msg.push_back(text[i]);
		send_message(msg);
	endtask

	// Sender holds off until every owed result has come out.
	task automatic pause_until_drained();
		in_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (decoded_queue.size() != 0);
	endtask

	// Alphabet extremes in full groups of three bytes.
	task automatic test_full_groups();
		send_text("AZaz09+/");
	endtask

	// "==" gives one byte, "=" gives two.
	task automatic test_padded_endings();
		send_text("QQ==");
		send_text("QUI=");
	endtask

	// Bytes of 128 and above, 0x00, misplaced '=', data after '=', bad length.
	task automatic test_malformed();
		send_message({8'hFF, PadChar, 8'h00});
		send_text("QQ=A");
		send_message({PadChar});
	endtask

	task automatic test_random_messages(input int symbol_budget);
		int stop_at;
		stop_at = symbols_sent + symbol_budget;
		while (symbols_sent < stop_at)
			send_message(random_message());
	endtask

	// Receiver: random back-pressure, and each accepted result checked in order.
	always @(posedge clk) begin : check_results
		result_t want;
		result_t got;
		out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			got.data_byte    = out_ch.data_byte;
			got.error        = out_ch.error;
			got.run_last     = out_ch.run_last;
			got.message_last = out_ch.message_last;
			if (decoded_queue.size() == 0) begin
				$display("%0t: unexpected result byte %02h err %0b rl %0b ml %0b", $time,
					got.data_byte, got.error, got.run_last, got.message_last);
				mismatch_count++;
			end else begin
				want = decoded_queue.pop_front();
				results_checked++;
				if (got.data_byte !== want.data_byte || got.error !== want.error ||
						got.run_last !== want.run_last ||
						got.message_last !== want.message_last) begin
					$display("%0t: expected byte %02h err %0b rl %0b ml %0b, got byte %02h err %0b rl %0b ml %0b",
						$time, want.data_byte, want.error, want.run_last, want.message_last,
						got.data_byte, got.error, got.run_last, got.message_last);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CycleLimit) begin
			$display("timeout after %0d cycles, %0d results still owed", cycle_count,
				decoded_queue.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		symbols_sent    = 0;
		messages_sent   = 0;
		bad_messages    = 0;
		send_idle_pct   = 18;
		recv_idle_pct   = 47;
		clear_group_state();
		arst_n            <= 1'b0;
		in_ch.valid       <= 1'b0;
		in_ch.symbol      <= 8'd0;
		in_ch.message_end <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_full_groups();
		test_padded_endings();
		test_malformed();
		test_random_messages(60);
		pause_until_drained();

		send_idle_pct = 47;
		recv_idle_pct = 18;
		test_random_messages(60);
		pause_until_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_messages(60);

		pause_until_drained();
		repeat (8) @(posedge clk);

		$display("sent %0d characters in %0d messages (%0d malformed), checked %0d results",
			symbols_sent, messages_sent, bad_messages, results_checked);
		$display("idle mixes covered: sender-light, receiver-light, none; %0d mismatches",
			mismatch_count);
		if (mismatch_count == 0 && decoded_queue.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// File: base64_stream_decoder_core.f
sv/b64d_pkg.sv
sv/b64d_if.sv
sv/b64d_decode.sv
sv/base64_stream_decoder_core.sv
tb/sv/base64_stream_decoder_core_tb.sv
